[hdl/vr2d_pkg.sv]
// vr2d_pkg: constants, CORDIC arctangent table and quadrant codes for vector_rotate_2d.
// No dependencies; imported by vr2d_req_if, the top level and the testbench.
`default_nettype none

package vr2d_pkg;

   localparam int ANGLE_WIDTH = 16;
   localparam int QUAD_WIDTH  = 2;
   localparam int RES_WIDTH   = ANGLE_WIDTH - QUAD_WIDTH;
   localparam int Z_SHIFT     = 16;
   localparam int CS_W        = 32;
   localparam int Z_W         = 33;
   localparam int FRAC_BITS   = 30;
   localparam int ATAN_LEN    = 24;

   localparam logic signed [CS_W-1:0] GAIN_Q30       = 32'sd652032874;
   localparam logic signed [CS_W-1:0] ROUND_HALF_Q30 = 32'sd536870912;

   localparam logic [QUAD_WIDTH-1:0] QUAD_0 = 2'd0;
   localparam logic [QUAD_WIDTH-1:0] QUAD_1 = 2'd1;
   localparam logic [QUAD_WIDTH-1:0] QUAD_2 = 2'd2;
   localparam logic [QUAD_WIDTH-1:0] QUAD_3 = 2'd3;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic signed [Z_W-1:0] atan_turn(input int unsigned i);
      logic [31:0] t;
      case (i)
         0:       t = 32'h20000000;
         1:       t = 32'h12E4051E;
         2:       t = 32'h09FB385B;
         3:       t = 32'h051111D4;
         4:       t = 32'h028B0D43;
         5:       t = 32'h0145D7E1;
         6:       t = 32'h00A2F61E;
         7:       t = 32'h00517C55;
         8:       t = 32'h0028BE53;
         9:       t = 32'h00145F2F;
         10:      t = 32'h000A2F98;
         11:      t = 32'h000517CC;
         12:      t = 32'h00028BE6;
         13:      t = 32'h000145F3;
         14:      t = 32'h0000A2FA;
         15:      t = 32'h0000517D;
         16:      t = 32'h000028BE;
         17:      t = 32'h0000145F;
         18:      t = 32'h00000A30;
         19:      t = 32'h00000518;
         20:      t = 32'h0000028C;
         21:      t = 32'h00000146;
         22:      t = 32'h000000A3;
         23:      t = 32'h00000051;
         default: t = 32'h00000000;
      endcase
      return $signed({1'b0, t});
   endfunction

endpackage

`default_nettype wire

[hdl/vr2d_if.sv]
// vr2d_req_if / vr2d_rsp_if: valid/ready channels carrying vectors in and rotated vectors out.
// Depends on vr2d_pkg.
`default_nettype none

interface vr2d_req_if #(parameter int COMPONENT_WIDTH = 24);
   import vr2d_pkg::*;

   logic                              valid;
   logic                              ready;
   logic signed [COMPONENT_WIDTH-1:0] x_in;
   logic signed [COMPONENT_WIDTH-1:0] y_in;
   logic [ANGLE_WIDTH-1:0]            turn_angle;

   modport source (output valid, output x_in, output y_in, output turn_angle, input ready);
   modport sink   (input valid, input x_in, input y_in, input turn_angle, output ready);
endinterface

interface vr2d_rsp_if #(parameter int COMPONENT_WIDTH = 24);
   logic                              valid;
   logic                              ready;
   logic signed [COMPONENT_WIDTH-1:0] x_out;
   logic signed [COMPONENT_WIDTH-1:0] y_out;

   modport source (output valid, output x_out, output y_out, input ready);
   modport sink   (input valid, input x_out, input y_out, output ready);
endinterface

`default_nettype wire

[hdl/vector_rotate_2d.sv]
// vector_rotate_2d: rotates a Q11.12 vector counter-clockwise by a 16-bit binary angle.
// Depends on vr2d_pkg and the channel interfaces in vr2d_if.sv.
//
// Takes one vector per clock while the result side is ready. One register stage captures
// the input, one stage per CORDIC iteration forms cos/sin of the angle within its
// quadrant, then a quadrant-mapping stage and a stage of four parallel multipliers feed
// the output register, which holds the rounded and saturated result. Every stage carries
// its own valid bit; a stall on the result side fills empty stages first, so input keeps
// flowing until the pipeline is full. A zero angle returns the input vector exactly. The
// interface instances must use the same COMPONENT_WIDTH as the block.
`default_nettype none

module vector_rotate_2d #(
   parameter int CORDIC_STAGES   = 16,
   parameter int COMPONENT_WIDTH = 24
) (
   input  wire logic  clock,
   input  wire logic  reset,
   vr2d_req_if.sink   req_if,
   vr2d_rsp_if.source rsp_if
);
   import vr2d_pkg::*;

   localparam int N      = CORDIC_STAGES;
   localparam int W      = COMPONENT_WIDTH;
   localparam int ST_MAP = N + 1;
   localparam int ST_MUL = N + 2;
   localparam int ST_OUT = N + 3;
   localparam int L      = N + 4;
   localparam int PROD_W = W + CS_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int SH_W   = SUM_W - FRAC_BITS;

   localparam logic signed [SUM_W-1:0] ROUND_Q = SUM_W'(ROUND_HALF_Q30);

   typedef struct packed {
      logic signed [W-1:0]   x;
      logic signed [W-1:0]   y;
      logic [QUAD_WIDTH-1:0] quad;
      logic                  zero;
   } side_type;

   logic [L-1:0] vld_ff;
   logic [L-1:0] vld_in;
   logic [L:0]   adv;

   logic signed [CS_W-1:0] cx_ff [0:N];
   logic signed [CS_W-1:0] cy_ff [0:N];
   logic signed [Z_W-1:0]  z_ff  [0:N];
   logic signed [CS_W-1:0] cx_in [0:N];
   logic signed [CS_W-1:0] cy_in [0:N];
   logic signed [Z_W-1:0]  z_in  [0:N];
   side_type               side_ff [0:ST_MUL];
   side_type               side_in;

   logic signed [CS_W-1:0]   cs_ff, sn_ff, cs_in, sn_in;
   logic signed [PROD_W-1:0] pxc_ff, pys_ff, pxs_ff, pyc_ff;
   logic signed [PROD_W-1:0] pxc_in, pys_in, pxs_in, pyc_in;
   logic signed [SUM_W-1:0]  sumx, sumy;
   logic signed [W-1:0]      xo_ff, yo_ff, xo_in, yo_in;

   function automatic logic signed [W-1:0] sat(input logic signed [SH_W-1:0] v);
      logic [SH_W-W:0] top;
      top = v[SH_W-1:W-1];
      if (&top || ~|top) begin
         return v[W-1:0];
      end
      return v[SH_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
   endfunction

   // ready chain: a stage may load when it is empty or its content moves on
   always_comb begin
      adv[L] = rsp_if.ready;
      for (int j = L - 1; j >= 0; j--) begin
         adv[j] = !vld_ff[j] || adv[j+1];
      end
      vld_in[0] = adv[0] ? req_if.valid : vld_ff[0];
      for (int j = 1; j < L; j++) begin
         vld_in[j] = adv[j] ? vld_ff[j-1] : vld_ff[j];
      end
   end

   assign req_if.ready = adv[0];
   assign rsp_if.valid = vld_ff[ST_OUT];
   assign rsp_if.x_out = xo_ff;
   assign rsp_if.y_out = yo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // input capture and CORDIC iterations
   always_comb begin
      logic signed [CS_W-1:0] dx;
      logic signed [CS_W-1:0] dy;
      side_in.x    = req_if.x_in;
      side_in.y    = req_if.y_in;
      side_in.quad = req_if.turn_angle[ANGLE_WIDTH-1 -: QUAD_WIDTH];
      side_in.zero = (req_if.turn_angle == '0);
      cx_in[0] = GAIN_Q30;
      cy_in[0] = '0;
      z_in[0]  = {{(Z_W - RES_WIDTH - Z_SHIFT){1'b0}},
                  req_if.turn_angle[RES_WIDTH-1:0], {Z_SHIFT{1'b0}}};
      for (int k = 1; k <= N; k++) begin
         dx = cy_ff[k-1] >>> (k - 1);
         dy = cx_ff[k-1] >>> (k - 1);
         if (!z_ff[k-1][Z_W-1]) begin
            cx_in[k] = cx_ff[k-1] - dx;
            cy_in[k] = cy_ff[k-1] + dy;
            z_in[k]  = z_ff[k-1] - atan_turn(k - 1);
         end else begin
            cx_in[k] = cx_ff[k-1] + dx;
            cy_in[k] = cy_ff[k-1] - dy;
            z_in[k]  = z_ff[k-1] + atan_turn(k - 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= N; j++) begin
         if (adv[j]) begin
            cx_ff[j] <= cx_in[j];
            cy_ff[j] <= cy_in[j];
            z_ff[j]  <= z_in[j];
            side_ff[j] <= (j == 0) ? side_in : side_ff[(j == 0) ? 0 : j - 1];
         end
      end
      if (adv[ST_MAP]) begin
         cs_ff           <= cs_in;
         sn_ff           <= sn_in;
         side_ff[ST_MAP] <= side_ff[N];
      end
      if (adv[ST_MUL]) begin
         pxc_ff          <= pxc_in;
         pys_ff          <= pys_in;
         pxs_ff          <= pxs_in;
         pyc_ff          <= pyc_in;
         side_ff[ST_MUL] <= side_ff[ST_MAP];
      end
      if (adv[ST_OUT]) begin
         xo_ff <= xo_in;
         yo_ff <= yo_in;
      end
   end

   // quadrant mapping
   always_comb begin
      case (side_ff[N].quad)
         QUAD_1: begin
            cs_in = -cy_ff[N];
            sn_in = cx_ff[N];
         end
         QUAD_2: begin
            cs_in = -cx_ff[N];
            sn_in = -cy_ff[N];
         end
         QUAD_3: begin
            cs_in = cy_ff[N];
            sn_in = -cx_ff[N];
         end
         default: begin
            cs_in = cx_ff[N];
            sn_in = cy_ff[N];
         end
      endcase
   end

   // products
   always_comb begin
      pxc_in = PROD_W'(side_ff[ST_MAP].x) * PROD_W'(cs_ff);
      pys_in = PROD_W'(side_ff[ST_MAP].y) * PROD_W'(sn_ff);
      pxs_in = PROD_W'(side_ff[ST_MAP].x) * PROD_W'(sn_ff);
      pyc_in = PROD_W'(side_ff[ST_MAP].y) * PROD_W'(cs_ff);
   end

   // round, shift and saturate, or pass the input through for a zero angle
   always_comb begin
      sumx = {pxc_ff[PROD_W-1], pxc_ff} - {pys_ff[PROD_W-1], pys_ff} + ROUND_Q;
      sumy = {pxs_ff[PROD_W-1], pxs_ff} + {pyc_ff[PROD_W-1], pyc_ff} + ROUND_Q;
      if (side_ff[ST_MUL].zero) begin
         xo_in = side_ff[ST_MUL].x;
         yo_in = side_ff[ST_MUL].y;
      end else begin
         xo_in = sat(sumx[SUM_W-1:FRAC_BITS]);
         yo_in = sat(sumy[SUM_W-1:FRAC_BITS]);
      end
   end

   // a transfer in always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> vld_ff[0])
      else $error("accepted vector missing from first stage");

   // input is refused only when every stage holds a vector
   a_full_only: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> &vld_ff)
      else $error("input stalled with a bubble in the pipeline");

   // a waiting result is never dropped
   a_out_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> vld_ff[ST_OUT])
      else $error("pending result lost");

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for vector_rotate_2d, directed extremes then random vectors/angles.
// Needs vr2d_pkg, vr2d_if.sv and vector_rotate_2d; predicts each rotation with its own CORDIC.

module tb;
   import vr2d_pkg::*;

   localparam int CW          = 24;
   localparam int STAGES      = 16;
   localparam int RANDOM_ITEMS = 2000;
   localparam int QUIET_LIMIT = 5000;
   localparam int TAIL_CYCLES = 40;
   localparam longint GAIN_FIX  = 652032874;
   localparam longint HALF_LSB  = 536870912;
   localparam longint COMP_MAX  = (longint'(1) <<< (CW - 1)) - 1;
   localparam longint COMP_MIN  = -COMP_MAX - 1;

   typedef logic signed [CW-1:0] comp_type;
   typedef logic [ANGLE_WIDTH-1:0] angle_type;

   typedef struct packed {
      comp_type  x;
      comp_type  y;
      angle_type angle;
      logic      drain_first;
   } vec_item_type;

   typedef struct packed {
      comp_type x;
      comp_type y;
   } rot_vec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vr2d_req_if #(.COMPONENT_WIDTH(CW)) req_ch ();
   vr2d_rsp_if #(.COMPONENT_WIDTH(CW)) rsp_ch ();

   vector_rotate_2d #(
      .CORDIC_STAGES   (STAGES),
      .COMPONENT_WIDTH (CW)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #2 clock = ~clock;

   vec_item_type pending_vecs[$];
   rot_vec_type  expected_vecs[$];
   int           total_items = 0;
   int           sent_cnt = 0;
   int           rcvd_cnt = 0;
   int           mismatch_cnt = 0;
   int           quiet_cycles = 0;

   // atan(2^-i) in 2^-32 turn
   function automatic longint atan_step(int i);
      case (i)
         0:       return 64'h20000000;
         1:       return 64'h12E4051E;
         2:       return 64'h09FB385B;
         3:       return 64'h051111D4;
         4:       return 64'h028B0D43;
         5:       return 64'h0145D7E1;
         6:       return 64'h00A2F61E;
         7:       return 64'h00517C55;
         8:       return 64'h0028BE53;
         9:       return 64'h00145F2F;
         10:      return 64'h000A2F98;
         11:      return 64'h000517CC;
         12:      return 64'h00028BE6;
         13:      return 64'h000145F3;
         14:      return 64'h0000A2FA;
         15:      return 64'h0000517D;
         16:      return 64'h000028BE;
         17:      return 64'h0000145F;
         18:      return 64'h00000A30;
         19:      return 64'h00000518;
         20:      return 64'h0000028C;
         21:      return 64'h00000146;
         22:      return 64'h000000A3;
         23:      return 64'h00000051;
         default: return 64'h0;
      endcase
   endfunction

   function automatic comp_type clamp_comp(longint v);
      if (v > COMP_MAX) return comp_type'(COMP_MAX);
      if (v < COMP_MIN) return comp_type'(COMP_MIN);
      return comp_type'(v);
   endfunction

   function automatic rot_vec_type rotate_vector(comp_type x, comp_type y, angle_type angle);
      longint      cx, cy, z, dx, dy, cs, sn, xv, yv;
      rot_vec_type r;
      if (angle == '0) begin
         r.x = x;
         r.y = y;
         return r;
      end
      cx = GAIN_FIX;
      cy = 0;
      z  = longint'(angle[RES_WIDTH-1:0]) <<< Z_SHIFT;
      for (int i = 0; i < STAGES; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (z >= 0) begin
            cx = cx - dx;
            cy = cy + dy;
            z  = z - atan_step(i);
         end else begin
            cx = cx + dx;
            cy = cy - dy;
            z  = z + atan_step(i);
         end
      end
      case (angle[ANGLE_WIDTH-1 -: QUAD_WIDTH])
         QUAD_1:  begin cs = -cy; sn = cx;  end
         QUAD_2:  begin cs = -cx; sn = -cy; end
         QUAD_3:  begin cs = cy;  sn = -cx; end
         default: begin cs = cx;  sn = cy;  end
      endcase
      xv = longint'(x);
      yv = longint'(y);
      r.x = clamp_comp((xv * cs - yv * sn + HALF_LSB) >>> 30);
      r.y = clamp_comp((xv * sn + yv * cs + HALF_LSB) >>> 30);
      return r;
   endfunction

   function automatic vec_item_type make_item(comp_type x, comp_type y, angle_type a,
                                              logic drain);
      vec_item_type it;
      it.x = x;
      it.y = y;
      it.angle = a;
      it.drain_first = drain;
      return it;
   endfunction

   function automatic comp_type pick_extreme();
      case ($urandom_range(4))
         0:       return comp_type'(COMP_MAX);
         1:       return comp_type'(COMP_MIN);
         2:       return comp_type'(0);
         3:       return comp_type'(-1);
         default: return comp_type'(1);
      endcase
   endfunction

   function automatic int idle_pct(bit sender);
      int phase_len;
      phase_len = total_items / 3;
      if (sent_cnt < phase_len) return sender ? 22 : 58;
      if (sent_cnt < 2 * phase_len) return sender ? 58 : 22;
      return 0;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, rcvd_cnt);
      mismatch_cnt++;
   endtask

   // driver
   vec_item_type nxt;
   bit           took;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         took = req_ch.valid && req_ch.ready;
         if (took) begin
            expected_vecs.push_back(rotate_vector(req_ch.x_in, req_ch.y_in, req_ch.turn_angle));
            sent_cnt <= sent_cnt + 1;
         end
         if (!req_ch.valid || took) begin
            if (pending_vecs.size() != 0
                && !(pending_vecs[0].drain_first && sent_cnt + int'(took) != rcvd_cnt)
                && $urandom_range(99) >= idle_pct(1'b1)) begin
               nxt = pending_vecs.pop_front();
               req_ch.x_in       <= nxt.x;
               req_ch.y_in       <= nxt.y;
               req_ch.turn_angle <= nxt.angle;
               req_ch.valid      <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   rot_vec_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_vecs.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_ch.x_out, 0);
            end else begin
               want = expected_vecs.pop_front();
               if (rsp_ch.x_out !== want.x) report_mismatch("x_out", rsp_ch.x_out, want.x);
               if (rsp_ch.y_out !== want.y) report_mismatch("y_out", rsp_ch.y_out, want.y);
            end
            rcvd_cnt <= rcvd_cnt + 1;
         end
         rsp_ch.ready <= ($urandom_range(99) >= idle_pct(1'b0));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      comp_type  vx, vy;
      angle_type ang;
      logic      drain;
      req_ch.valid      = 1'b0;
      req_ch.x_in       = '0;
      req_ch.y_in       = '0;
      req_ch.turn_angle = '0;
      rsp_ch.ready      = 1'b0;

      // directed: extremes, quadrant edges, zero-angle bypass, saturation
      pending_vecs.push_back(make_item(comp_type'(COMP_MAX), comp_type'(0), 16'd0, 1'b0));
      pending_vecs.push_back(make_item(comp_type'(COMP_MIN), comp_type'(COMP_MIN), 16'd0, 1'b0));
      pending_vecs.push_back(make_item(comp_type'(-1), comp_type'(1), 16'd0, 1'b0));
      pending_vecs.push_back(make_item(comp_type'(4096), comp_type'(0), 16'd1, 1'b0));
      pending_vecs.push_back(make_item(comp_type'(4096), comp_type'(0), 16'd16384, 1'b0));
      pending_vecs.push_back(make_item(comp_type'(4096), comp_type'(0), 16'd32768, 1'b0));
      pending_vecs.push_back(make_item(comp_type'(4096), comp_type'(0), 16'd49152, 1'b0));
      pending_vecs.push_back(make_item(comp_type'(4096), comp_type'(4096), 16'd65535, 1'b0));
      pending_vecs.push_back(make_item(comp_type'(4096), comp_type'(0), 16'd8192, 1'b0));
      pending_vecs.push_back(make_item(comp_type'(4096), comp_type'(0), 16'd16383, 1'b0));
      pending_vecs.push_back(make_item(comp_type'(COMP_MAX), comp_type'(COMP_MAX), 16'd8192,
                                       1'b0));
      pending_vecs.push_back(make_item(comp_type'(COMP_MIN), comp_type'(COMP_MIN), 16'd8192,
                                       1'b0));
      pending_vecs.push_back(make_item(comp_type'(COMP_MAX), comp_type'(COMP_MIN), 16'd24576,
                                       1'b0));
      pending_vecs.push_back(make_item(comp_type'(COMP_MIN), comp_type'(0), 16'd32768, 1'b0));
      pending_vecs.push_back(make_item(comp_type'(COMP_MIN), comp_type'(COMP_MAX), 16'd32768,
                                       1'b0));
      pending_vecs.push_back(make_item(comp_type'(COMP_MIN), comp_type'(COMP_MIN), 16'd40960,
                                       1'b0));
      pending_vecs.push_back(make_item(comp_type'(COMP_MAX), comp_type'(COMP_MAX), 16'd65535,
                                       1'b0));
      pending_vecs.push_back(make_item(comp_type'(0), comp_type'(0), 16'd40000, 1'b0));
      pending_vecs.push_back(make_item(comp_type'(-1), comp_type'(-1), 16'd12345, 1'b0));
      pending_vecs.push_back(make_item(comp_type'(1), comp_type'(-1), 16'd49151, 1'b0));
      pending_vecs.push_back(make_item(comp_type'(COMP_MAX), comp_type'(0), 16'd57344, 1'b0));
      pending_vecs.push_back(make_item(comp_type'(0), comp_type'(COMP_MIN), 16'd16384, 1'b0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         vx  = comp_type'($urandom);
         vy  = comp_type'($urandom);
         ang = angle_type'($urandom);
         case ($urandom_range(9))
            5: begin
               vx = comp_type'(int'($urandom_range(8191)) - 4096);
               vy = comp_type'(int'($urandom_range(8191)) - 4096);
            end
            6: ang = {2'($urandom_range(3)), 14'd0} + angle_type'($urandom_range(6)) - 16'd3;
            7: begin
               vx = pick_extreme();
               vy = pick_extreme();
            end
            8: ang = '0;
            9: begin
               vx  = comp_type'(COMP_MAX - longint'($urandom_range(65535)));
               vy  = ($urandom_range(1) != 0) ? comp_type'(COMP_MIN) : comp_type'(COMP_MAX);
               ang = {3'($urandom_range(7)), 13'd0} + angle_type'($urandom_range(255)) - 16'd128;
            end
            default: ;
         endcase
         drain = (n == 0) || (n == RANDOM_ITEMS / 3 + 50) || (n == 2 * RANDOM_ITEMS / 3 + 50);
         pending_vecs.push_back(make_item(vx, vy, ang, drain));
      end
      total_items = pending_vecs.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (sent_cnt == total_items);
      wait (rcvd_cnt == total_items);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_vecs.size() != 0)
         report_mismatch("results never returned", 0, expected_vecs.size());
      if (mismatch_cnt == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
